// ----- rtl/pass_dependency_cycle_detect_macros.svh -----
// Assertion macros for the pass dependency cycle detector.
// No dependencies.
`ifndef PASS_DEPENDENCY_CYCLE_DETECT_MACROS_SVH
`define PASS_DEPENDENCY_CYCLE_DETECT_MACROS_SVH
// Implication check on a clock with async reset.
`define PDCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication check.
`define PDCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/pdcd_pkg.sv -----
// Package of the pass dependency cycle detector: FSM state, commands, status.
// No dependencies.
package pdcd_pkg;
	localparam int unsigned PassIdxW = 5;
	localparam int unsigned ResIdW = 6;
	localparam int unsigned RoleW = 2;

	localparam logic [RoleW-1:0] RoleWrite = 2'd0;
	localparam logic [RoleW-1:0] RoleRead = 2'd1;
	localparam logic [RoleW-1:0] RoleCopySrc = 2'd2;
	localparam logic [RoleW-1:0] RoleCopyDst = 2'd3;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_PRED,
		ST_ROUND,
		ST_FIND,
		ST_OUT,
		ST_CLEAR
	} state_t;

	// Controller to datapath commands.
	typedef struct packed {
		logic load;       // store the accepted reference
		logic pred_start; // reset pass counter and removal set
		logic pred_step;  // build predecessors of one pass
		logic round_step; // examine one pass for removal
		logic round_start;// start a new removal round
		logic find_step;  // scan one pass for the lowest survivor
		logic find_start;
		logic clear_step; // clear one pass row
		logic clear_start;
	} cmd_t;

	// Datapath to controller status.
	typedef struct packed {
		logic cnt_last; // counter sits on the last pass
		logic changed;  // the round removed at least one pass
	} sts_t;
endpackage

// ----- rtl/pdcd_if.sv -----
// Valid/ready channel interface carrying a payload of type T.
// No dependencies.
interface pdcd_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/pass_dependency_cycle_detect.sv -----
// Pass dependency cycle detector: loads resource references, then runs
// Kahn's removal over the pass graph when the last reference arrives.
// Channel in: valid/ready with pass_index, pass_is_copy, ref_role,
// rsrc_id, last_ref. References are accepted only while loading.
// Channel out: one transaction per data set (has_cycle, cycle_pass_index),
// raised after the reference carrying last_ref.
// After last_ref the check runs a predecessor build, then removal rounds (up
// to MAX_PASSES+1 rounds), then the survivor scan; each phase steps the pass
// counter over the mask rows.
// While the result waits the input is stalled; once taken, a clearing pass
// empties the stores before loading resumes.
// Reset clears the mask, presence and removal stores at once and returns the block to loading.
// Depends on pdcd_pkg, pdcd_if, pdcd_ctrl, pdcd_dp and the macros header.
`include "pass_dependency_cycle_detect_macros.svh"
module pass_dependency_cycle_detect #(
	parameter int unsigned MAX_PASSES = 32,
	parameter int unsigned MAX_RESOURCES = 64
) (
	input logic clk,
	input logic arst_n,
	pdcd_if.sink in_ch,
	pdcd_if.source out_ch
);
	import pdcd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic out_no_cycle;
	logic last_fire;

	pdcd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_last(in_ch.data.last_ref), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd)
	);

	pdcd_dp #(.MAX_PASSES(MAX_PASSES), .MAX_RESOURCES(MAX_RESOURCES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.pass_index(in_ch.data.pass_index), .pass_is_copy(in_ch.data.pass_is_copy),
		.ref_role(in_ch.data.ref_role), .rsrc_id(in_ch.data.rsrc_id),
		.has_cycle(out_ch.data.has_cycle),
		.cycle_pass_index(out_ch.data.cycle_pass_index)
	);

	// Checks
	assign out_no_cycle = out_ch.valid && !out_ch.data.has_cycle;
	assign last_fire = in_ch.valid && in_ch.ready && in_ch.data.last_ref;

	`PDCD_ASSERT_IMP(a_no_ready_while_out, clk, arst_n, out_ch.valid, !in_ch.ready)
	`PDCD_ASSERT_IMP(a_idx_zero_no_cycle, clk, arst_n, out_no_cycle, out_ch.data.cycle_pass_index == '0)
	`PDCD_ASSERT_NEXT(a_last_stalls, clk, arst_n, last_fire, !in_ch.ready)
endmodule

// ----- rtl/pdcd_ctrl.sv -----
// Controller of the pass dependency cycle detector.
// Depends on pdcd_pkg.
module pdcd_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_last,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input pdcd_pkg::sts_t sts,
	output pdcd_pkg::cmd_t cmd
);
	import pdcd_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.pred_start = 1'b1;
						state_d = ST_PRED;
					end
				end
			end
			ST_PRED: begin
				cmd.pred_step = 1'b1;
				if (sts.cnt_last) begin
					cmd.round_start = 1'b1;
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				cmd.round_step = 1'b1;
				if (sts.cnt_last) begin
					if (sts.changed) cmd.round_start = 1'b1;
					else begin
						cmd.find_start = 1'b1;
						state_d = ST_FIND;
					end
				end
			end
			ST_FIND: begin
				cmd.find_step = 1'b1;
				if (sts.cnt_last) state_d = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					cmd.clear_start = 1'b1;
					state_d = ST_CLEAR;
				end
			end
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.cnt_last) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end
endmodule

// ----- rtl/pdcd_dp.sv -----
// Datapath: per-pass write/read masks, predecessor sets, removal scan.
// Depends on pdcd_pkg.
module pdcd_dp #(
	parameter int unsigned MAX_PASSES = 32,
	parameter int unsigned MAX_RESOURCES = 64
) (
	input logic clk,
	input logic arst_n,
	input pdcd_pkg::cmd_t cmd,
	output pdcd_pkg::sts_t sts,
	input logic [pdcd_pkg::PassIdxW-1:0] pass_index,
	input logic pass_is_copy,
	input logic [pdcd_pkg::RoleW-1:0] ref_role,
	input logic [pdcd_pkg::ResIdW-1:0] rsrc_id,
	output logic has_cycle,
	output logic [pdcd_pkg::PassIdxW-1:0] cycle_pass_index
);
	import pdcd_pkg::*;
	localparam int unsigned CntW = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

	// Mask rows: few enough to stay in flops; the read row is selected by the counter.
	logic [MAX_RESOURCES-1:0] wmask_q [MAX_PASSES];
	logic [MAX_RESOURCES-1:0] rmask_q [MAX_PASSES];
	logic [MAX_PASSES-1:0] preds_q [MAX_PASSES];
	logic [MAX_PASSES-1:0] present_q, removed_q;
	logic [CntW-1:0] cnt_q;
	logic changed_q, found_q;
	logic [PassIdxW-1:0] first_q;

	logic pass_ok, res_ok, set_w, set_r;
	logic rm_cand;
	logic [MAX_RESOURCES-1:0] res_bit;
	logic [CntW-1:0] pidx;
	logic [MAX_PASSES-1:0] pred_row;
	logic [MAX_PASSES-1:0] cbit;

	assign pass_ok = {27'b0, pass_index} < MAX_PASSES;
	assign res_ok = (rsrc_id != '0) && ({1'b0, rsrc_id} < (ResIdW+1)'(MAX_RESOURCES));
	assign pidx = CntW'(pass_index);
	assign res_bit = MAX_RESOURCES'(1) << rsrc_id;
	assign cbit = MAX_PASSES'(1) << cnt_q;

	// Role decode
	always_comb begin
		set_w = 1'b0;
		set_r = 1'b0;
		case (ref_role)
			RoleWrite: set_w = 1'b1;
			RoleRead: set_r = !pass_is_copy;
			RoleCopySrc: set_r = pass_is_copy;
			default: set_w = pass_is_copy;
		endcase
	end

	// Predecessors of pass cnt: every other writer whose row meets its read row
	always_comb begin
		for (int i = 0; i < MAX_PASSES; i++)
			pred_row[i] = (CntW'(i) != cnt_q) && ((wmask_q[i] & rmask_q[cnt_q]) != '0);
	end

	// Pass at the counter is live and has no live predecessor
	assign rm_cand = present_q[cnt_q] && !removed_q[cnt_q]
		&& ((preds_q[cnt_q] & ~removed_q) == '0);

	assign sts.cnt_last = (cnt_q == CntW'(MAX_PASSES-1));
	// Includes a removal of the last pass in this very cycle
	assign sts.changed = changed_q || rm_cand;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			removed_q <= '0;
			cnt_q <= '0;
			changed_q <= 1'b0;
			found_q <= 1'b0;
			first_q <= '0;
			for (int i = 0; i < MAX_PASSES; i++) begin
				wmask_q[i] <= '0;
				rmask_q[i] <= '0;
			end
		end else begin
			if (cmd.load && pass_ok) begin
				present_q[pidx] <= 1'b1;
				if (res_ok && set_w) wmask_q[pidx] <= wmask_q[pidx] | res_bit;
				if (res_ok && set_r) rmask_q[pidx] <= rmask_q[pidx] | res_bit;
			end
			if (cmd.pred_start || cmd.clear_start || cmd.find_start) cnt_q <= '0;
			else if (cmd.pred_step || cmd.round_step || cmd.find_step || cmd.clear_step)
				cnt_q <= sts.cnt_last ? '0 : cnt_q + 1'b1;
			if (cmd.pred_start) removed_q <= '0;
			if (cmd.round_step && rm_cand) removed_q <= removed_q | cbit;
			if (cmd.round_start) changed_q <= 1'b0;
			else if (cmd.round_step && rm_cand) changed_q <= 1'b1;
			if (cmd.find_start) found_q <= 1'b0;
			if (cmd.find_step && !found_q && present_q[cnt_q] && !removed_q[cnt_q]) begin
				found_q <= 1'b1;
				first_q <= PassIdxW'(cnt_q);
			end
			if (cmd.clear_step) begin
				wmask_q[cnt_q] <= '0;
				rmask_q[cnt_q] <= '0;
				present_q <= '0;
				removed_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pred_step) preds_q[cnt_q] <= pred_row;
	end

	assign has_cycle = found_q;
	assign cycle_pass_index = found_q ? first_q : '0;
endmodule

// ----- tb/pass_dependency_cycle_detect_tb.sv -----
// Testbench for the pass dependency cycle detector: drives resource references,
// predicts the cycle verdict of each data set and checks every result.
// Depends on pdcd_pkg, pdcd_if and pass_dependency_cycle_detect.
`timescale 1ns / 100ps
module pass_dependency_cycle_detect_tb;
	import pdcd_pkg::*;

	localparam int NPASS = 32;
	localparam int NRES = 64;
	localparam int WATCHDOG_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 1300;
	localparam int LONG_HOLD = 400;

	typedef struct packed {
		logic [PassIdxW-1:0] pass_index;
		logic pass_is_copy;
		logic [RoleW-1:0] ref_role;
		logic [ResIdW-1:0] rsrc_id;
		logic last_ref;
	} ref_t;

	typedef struct packed {
		logic has_cycle;
		logic [PassIdxW-1:0] cycle_pass_index;
	} verdict_t;

	typedef struct {
		ref_t r;
		bit drain_first; // sender waits until every verdict is in
	} pending_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pdcd_if #(.T(ref_t)) in_ch ();
	pdcd_if #(.T(verdict_t)) out_ch ();

	pass_dependency_cycle_detect u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always #5 clk = ~clk;

	pending_t ref_queue[$];
	verdict_t verdict_queue[$];
	logic [NRES-1:0] writes_of[NPASS];
	logic [NRES-1:0] reads_of[NPASS];
	logic [NPASS-1:0] present;
	int refs_sent = 0;
	int verdicts_seen = 0;
	int cycles_seen = 0;
	int mismatches = 0;
	int idle_pct = 0;
	int stall_pct = 0;
	bit stim_done = 0;

	// Load one reference into the shadow graph; on last_ref run Kahn's removal.
	task automatic track_ref(input ref_t r);
		logic [NPASS-1:0] preds[NPASS];
		logic [NPASS-1:0] gone;
		logic [NPASS-1:0] left;
		logic [ResIdW-1:0] res;
		bit changed;
		verdict_t v;
		res = r.rsrc_id;
		present[r.pass_index] = 1'b1;
		if (res != 0) begin
			case (r.ref_role)
				RoleWrite: writes_of[r.pass_index][res] = 1'b1;
				RoleRead: if (!r.pass_is_copy) reads_of[r.pass_index][res] = 1'b1;
				RoleCopySrc: if (r.pass_is_copy) reads_of[r.pass_index][res] = 1'b1;
				default: if (r.pass_is_copy) writes_of[r.pass_index][res] = 1'b1;
			endcase
		end
		if (!r.last_ref)
			return;
		for (int j = 0; j < NPASS; j++) begin
			preds[j] = '0;
			for (int i = 0; i < NPASS; i++)
				if (i != j && (writes_of[i] & reads_of[j]) != 0)
					preds[j][i] = 1'b1;
		end
		gone = '0;
		for (int rnd = 0; rnd <= NPASS; rnd++) begin
			changed = 0;
			for (int j = 0; j < NPASS; j++) begin
				if (present[j] && !gone[j] && (preds[j] & ~gone) == 0) begin
					gone[j] = 1'b1;
					changed = 1;
				end
			end
			if (!changed)
				break;
		end
		left = present & ~gone;
		v = '0;
		if (left != 0) begin
			v.has_cycle = 1'b1;
			for (int j = NPASS - 1; j >= 0; j--)
				if (left[j])
					v.cycle_pass_index = PassIdxW'(j);
		end
		verdict_queue = {verdict_queue, v};
		for (int i = 0; i < NPASS; i++) begin
			writes_of[i] = '0;
			reads_of[i] = '0;
		end
		present = '0;
	endtask

	task automatic add_ref(input int p, input int cp, input int role, input int res,
			input int last, input bit drain = 0);
		pending_t e;
		e.r.pass_index = PassIdxW'(p);
		e.r.pass_is_copy = 1'(cp);
		e.r.ref_role = RoleW'(role);
		e.r.rsrc_id = ResIdW'(res);
		e.r.last_ref = 1'(last);
		e.drain_first = drain;
		ref_queue = {ref_queue, e};
	endtask

	// Random data set: small pass and resource ranges make edges and cycles likely.
	task automatic add_random_set(input bit drain);
		int n;
		int pmax;
		int rmax;
		n = ($urandom_range(9) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
		pmax = ($urandom_range(4) == 0) ? 31 : $urandom_range(7, 1);
		rmax = ($urandom_range(4) == 0) ? 63 : $urandom_range(8, 2);
		for (int k = 0; k < n; k++)
			add_ref($urandom_range(pmax), $urandom_range(1), $urandom_range(3),
				($urandom_range(15) == 0) ? 0 : $urandom_range(rmax, 1),
				k == n - 1, drain && k == 0);
	endtask

	// Stimulus
	initial begin
		present = '0;
		for (int i = 0; i < NPASS; i++) begin
			writes_of[i] = '0;
			reads_of[i] = '0;
		end
		// extreme indices, plain edge 31 -> 0, no cycle
		add_ref(31, 0, RoleWrite, 63, 0);
		add_ref(0, 0, RoleRead, 63, 1);
		// two-pass cycle, lowest survivor 1
		add_ref(1, 0, RoleWrite, 5, 0);
		add_ref(2, 0, RoleRead, 5, 0);
		add_ref(2, 0, RoleWrite, 6, 0);
		add_ref(1, 0, RoleRead, 6, 1);
		// copy passes forming a cycle with a mismatched read ignored
		add_ref(3, 1, RoleCopySrc, 7, 0);
		add_ref(3, 1, RoleCopyDst, 8, 0);
		add_ref(4, 1, RoleCopySrc, 8, 0);
		add_ref(4, 1, RoleCopyDst, 7, 0);
		add_ref(4, 1, RoleRead, 9, 0);
		add_ref(5, 0, RoleCopyDst, 9, 1);
		// role not matching kind breaks would-be cycle
		add_ref(6, 0, RoleWrite, 10, 0);
		add_ref(7, 0, RoleCopySrc, 10, 0);
		add_ref(7, 0, RoleWrite, 11, 0);
		add_ref(6, 0, RoleRead, 11, 1);
		// invalid resource only, then empty single pass
		add_ref(9, 1, RoleWrite, 0, 1);
		// self loop is no cycle
		add_ref(12, 0, RoleWrite, 20, 0);
		add_ref(12, 0, RoleRead, 20, 1);
		// mixed kind within one pass
		add_ref(30, 1, RoleWrite, 42, 0);
		add_ref(29, 0, RoleRead, 42, 0);
		add_ref(29, 1, RoleCopyDst, 21, 0);
		add_ref(30, 0, RoleRead, 21, 1, 1);
		while (ref_queue.size() < 1450)
			add_random_set(ref_queue.size() % 300 < 20);
		stim_done = 1;
	end

	// Driver: present pending references, idling by phase
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (in_ch.valid && in_ch.ready) begin
				track_ref(in_ch.data);
				refs_sent++;
			end
			case ((refs_sent / 180) % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 49; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 49; end
				default: begin idle_pct = 27; stall_pct = 27; end
			endcase
			if (ref_queue.size() > 0 && !(ref_queue[0].drain_first && verdict_queue.size() > 0)
					&& $urandom_range(99) >= idle_pct) begin
				in_ch.data <= ref_queue[0].r;
				ref_queue.pop_front();
				in_ch.valid <= 1'b1;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Monitor: check each verdict transaction; one long hold-off to fill the block
	int hold_left = 0;
	bit long_hold_done = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				verdicts_seen++;
				if (verdict_queue.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected verdict: has_cycle=%0d pass=%0d",
							out_ch.data.has_cycle, out_ch.data.cycle_pass_index);
				end else begin
					if (out_ch.data.has_cycle) cycles_seen++;
					if (out_ch.data !== verdict_queue[0]) begin
						mismatches++;
						if (mismatches <= 10)
							$display("verdict %0d: expected has_cycle=%0d pass=%0d, got %0d/%0d",
								verdicts_seen, verdict_queue[0].has_cycle,
								verdict_queue[0].cycle_pass_index,
								out_ch.data.has_cycle, out_ch.data.cycle_pass_index);
					end
					verdict_queue.pop_front();
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (!long_hold_done && verdicts_seen == 12) begin
				long_hold_done = 1;
				hold_left = LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= $urandom_range(99) >= stall_pct;
			end
		end
	end

	// Watchdog on cycles with no transaction on either channel
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("pass_dependency_cycle_detect verification failed");
			$finish;
		end
	end

	// Reset and end of run
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait (stim_done);
		while (ref_queue.size() > 0 || in_ch.valid || verdict_queue.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d references, %0d data set verdicts (%0d with a cycle)",
			refs_sent, verdicts_seen, cycles_seen);
		if (mismatches == 0 && verdict_queue.size() == 0)
			$display("pass_dependency_cycle_detect verification clean");
		else
			$display("pass_dependency_cycle_detect verification failed");
		$finish;
	end
endmodule
